FILE: design/pre_pkg.sv
// Shared types and constants for the printable run extractor.
`default_nettype none

package pre_pkg;

    localparam int RUN_MIN    = 8;
    localparam int HOLD_DEPTH = (RUN_MIN > 1) ? RUN_MIN - 1 : 1;
    localparam int CNT_W      = $clog2(RUN_MIN + 1);
    localparam int POS_W      = (RUN_MIN > 1) ? $clog2(RUN_MIN) : 1;
    localparam int IDX_W      = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

    localparam logic [7:0] NL_BYTE = 8'h0A;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_burst;
    } out_item_t;

    // Burst load request from the run tracker to the output stage.
    typedef struct packed {
        logic             emit;
        logic [POS_W-1:0] held_n;
        logic [7:0]       final_byte;
    } burst_t;

    function automatic logic is_printable(input logic [7:0] b);
        return ((b >= 8'h20) && (b <= 8'h7E)) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

endpackage

`default_nettype wire

FILE: design/pre_tracker.sv
// Input register, run state, held byte store and per-item decision logic.
`default_nettype none

module pre_tracker (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire pre_pkg::in_item_t         in_item,
    input  wire logic                      burst_free,
    output pre_pkg::burst_t                burst,
    input  wire logic [pre_pkg::IDX_W-1:0] rd_idx,
    output logic [7:0]                     rd_data
);
    import pre_pkg::*;

    logic             in_valid_reg;
    in_item_t         in_item_reg;
    logic [CNT_W-1:0] run_reg;
    logic [CNT_W-1:0] run_next;
    logic             lnl_reg;
    logic             lnl_next;
    logic [7:0]       held_reg [HOLD_DEPTH];

    logic             advance;
    logic             printable;
    logic             hold_wr;
    burst_t           burst_c;

    assign advance  = in_valid_reg && burst_free;
    assign in_ready = !in_valid_reg || burst_free;
    assign rd_data  = held_reg[rd_idx];

    always_comb
    begin
        printable          = is_printable(in_item_reg.data_byte);
        run_next           = run_reg;
        lnl_next           = lnl_reg;
        hold_wr            = 1'b0;
        burst_c.emit       = 1'b0;
        burst_c.held_n     = '0;
        burst_c.final_byte = in_item_reg.data_byte;
        if (printable)
        begin
            if (run_reg == CNT_W'(RUN_MIN))
            begin
                burst_c.emit = 1'b1;
            end
            else if (run_reg == CNT_W'(RUN_MIN - 1))
            begin
                // run qualifies now: flush the held bytes, then this one
                burst_c.emit   = 1'b1;
                burst_c.held_n = POS_W'(run_reg);
                run_next       = CNT_W'(RUN_MIN);
            end
            else
            begin
                hold_wr  = 1'b1;
                run_next = run_reg + CNT_W'(1);
            end
            lnl_next = (in_item_reg.data_byte == NL_BYTE);
        end
        else
        begin
            if ((run_reg == CNT_W'(RUN_MIN)) && !lnl_reg)
            begin
                burst_c.emit = 1'b1;
            end
            burst_c.final_byte = NL_BYTE;
            run_next           = '0;
            lnl_next           = 1'b0;
        end
        if (in_item_reg.end_of_stream)
        begin
            run_next = '0;
            lnl_next = 1'b0;
        end
        burst      = burst_c;
        burst.emit = burst_c.emit && advance;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            run_reg      <= '0;
            lnl_reg      <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
            begin
                run_reg <= run_next;
                lnl_reg <= lnl_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_item_reg <= in_item;
        if (advance && hold_wr)
            held_reg[run_reg[IDX_W-1:0]] <= in_item_reg.data_byte;
    end

endmodule

`default_nettype wire

FILE: design/pre_burst.sv
// Result register that plays out a burst of held bytes and the closing byte.
`default_nettype none

module pre_burst (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire pre_pkg::burst_t           burst,
    output logic                           burst_free,
    output logic [pre_pkg::IDX_W-1:0]      rd_idx,
    input  wire logic [7:0]                rd_data,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output pre_pkg::out_item_t             out_item
);
    import pre_pkg::*;

    logic             busy_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] held_n_reg;
    logic [7:0]       final_reg;
    logic             at_last;

    assign at_last    = (pos_reg == held_n_reg);
    assign burst_free = !busy_reg || (out_ready && at_last);
    assign rd_idx     = pos_reg[IDX_W-1:0];
    assign out_valid  = busy_reg;

    always_comb
    begin
        out_item.out_byte      = at_last ? final_reg : rd_data;
        out_item.last_of_burst = at_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= '0;
        end
        else if (burst.emit)
        begin
            busy_reg <= 1'b1;
            pos_reg  <= '0;
        end
        else if (busy_reg && out_ready)
        begin
            // drop out after the closing byte, else advance through the held bytes
            if (at_last)
                busy_reg <= 1'b0;
            else
                pos_reg <= pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (burst.emit)
        begin
            held_n_reg <= burst.held_n;
            final_reg  <= burst.final_byte;
        end
    end

endmodule

`default_nettype wire

FILE: design/printable_run_extractor.sv
// Top level of the printable run extractor.
// Each item passes the input register, then the result register, before its first
// result is valid. Throughput: one item per cycle while out_ready is set; an item
// that completes a run plays out RUN_MIN results, one per cycle while out_ready is
// set; the input register takes one more item, then input stalls.
// Reset (rst_n, async, active low) clears run length, newline flag and handshake
// state; the held byte store is not cleared and is only read after being written.
`default_nettype none

module printable_run_extractor (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire pre_pkg::in_item_t  in_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output pre_pkg::out_item_t      out_item
);
    import pre_pkg::*;

    burst_t           burst;
    logic             burst_free;
    logic [IDX_W-1:0] rd_idx;
    logic [7:0]       rd_data;

    pre_tracker u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .burst_free (burst_free),
        .burst      (burst),
        .rd_idx     (rd_idx),
        .rd_data    (rd_data)
    );

    pre_burst u_burst (
        .clk        (clk),
        .rst_n      (rst_n),
        .burst      (burst),
        .burst_free (burst_free),
        .rd_idx     (rd_idx),
        .rd_data    (rd_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

    // no new burst while one is still playing out
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !(out_ready && out_item.last_of_burst)) |-> !burst.emit)
        else $error("burst loaded over a draining burst");

    a_burst_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_item.last_of_burst && !burst.emit) |=> !out_valid)
        else $error("output still valid after last item of burst");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no burst pending");

endmodule

`default_nettype wire
